### sv/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg: shared types for the HSV to RGBA pixel converter
// Hue sector codes used by the channel select stage.
// ----------------------------------------------------------------------------
package hsv_pkg;

	// Six hue sectors, red at 0; codes 6 and 7 never occur
	typedef enum logic [2:0] {
		SEC_RED_YEL  = 3'd0,
		SEC_YEL_GRN  = 3'd1,
		SEC_GRN_CYN  = 3'd2,
		SEC_CYN_BLU  = 3'd3,
		SEC_BLU_MAG  = 3'd4,
		SEC_MAG_RED  = 3'd5
	} sector_t;

	localparam int PIX_W = 8;

endpackage

### sv/hsv_in_if.sv
// ----------------------------------------------------------------------------
// hsv_in_if: HSV plus alpha pixel channel
// Fixed-point fractions with FRAC_BITS fraction bits, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hsv_in_if #(
	parameter int FRAC_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [FRAC_BITS:0]   hue;
	logic [FRAC_BITS:0]   saturation;
	logic [FRAC_BITS:0]   brightness;
	logic [FRAC_BITS:0]   alpha_level;

	modport source (output valid, hue, saturation, brightness, alpha_level, input ready);
	modport sink   (input valid, hue, saturation, brightness, alpha_level, output ready);
endinterface

### sv/rgb_out_if.sv
// ----------------------------------------------------------------------------
// rgb_out_if: 8-bit RGBA pixel channel
// One pixel per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rgb_out_if;
	logic                       valid;
	logic                       ready;
	logic [hsv_pkg::PIX_W-1:0]  red;
	logic [hsv_pkg::PIX_W-1:0]  green;
	logic [hsv_pkg::PIX_W-1:0]  blue;
	logic [hsv_pkg::PIX_W-1:0]  alpha;

	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

### sv/hsv_to_rgb_pixel.sv
// Four register stages s1 to s4, each with its own valid bit, carry every pixel.
// Throughput: one pixel per cycle while the output is not stalled.
// A stage loads whenever it is empty or the stage after it moves, so bubbles close up
// and a stalled output still lets upstream stages fill.
// Reset (arst_n low) clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel: HSV plus alpha to 8-bit RGBA converter
// Six-sector HSV conversion in fixed point, rounded half up, fully pipelined.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	hsv_in_if.sink       pixel_hsv,
	rgb_out_if.source    pixel_rgb
);

	localparam int FW  = FRAC_BITS;
	localparam int VW  = FRAC_BITS + 8;       // brightness * 255
	localparam int H6W = FRAC_BITS + 3;       // hue * 6 + 1
	localparam int PW  = 2 * FRAC_BITS + 9;   // brightness * 255 * factor
	localparam int CW  = hsv_pkg::PIX_W;

	localparam logic [FW:0]   ONE_V   = {1'b1, {FW{1'b0}}};
	localparam logic [VW-1:0] HALF_V  = VW'(1) << (FW - 1);
	localparam logic [PW-1:0] HALF2_V = PW'(1) << (2 * FW - 1);

	function automatic logic [CW-1:0] round_prod(input logic [PW-1:0] p);
		logic [PW-1:0] sum;
		sum = p + HALF2_V;
		return sum[2*FW+CW-1:2*FW];
	endfunction

	// stage enables: a stage loads when empty or when the next one loads
	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	assign en4 = !v_s4 || pixel_rgb.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pixel_hsv.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pixel_hsv.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// ---------------- stage 1: clamp, hue sector, V*255, alpha ----------------
	logic [FW-1:0]   hue_w;
	logic [H6W-1:0]  h6;
	logic [FW:0]     sat_c, bri_c, alp_c;
	logic [VW:0]     v_tmp, a_tmp;
	logic [VW-1:0]   v255, iv_sum, a_sum;

	always_comb begin
		// hue of one or more wraps to zero
		hue_w  = pixel_hsv.hue[FW] ? '0 : pixel_hsv.hue[FW-1:0];
		h6     = ({3'b000, hue_w} << 2) + ({3'b000, hue_w} << 1) + H6W'(1);
		sat_c  = pixel_hsv.saturation[FW]  ? ONE_V : pixel_hsv.saturation;
		bri_c  = pixel_hsv.brightness[FW]  ? ONE_V : pixel_hsv.brightness;
		alp_c  = pixel_hsv.alpha_level[FW] ? ONE_V : pixel_hsv.alpha_level;
		v_tmp  = {bri_c, 8'h00} - {8'h00, bri_c};
		a_tmp  = {alp_c, 8'h00} - {8'h00, alp_c};
		v255   = v_tmp[VW-1:0];
		iv_sum = v255 + HALF_V;
		a_sum  = a_tmp[VW-1:0] + HALF_V;
	end

	logic            grey_s1;
	logic [2:0]      sector_s1;
	logic [FW-1:0]   f_s1;
	logic [FW:0]     s_s1, ns_s1;
	logic [VW-1:0]   v255_s1;
	logic [CW-1:0]   iv_s1, alpha_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			grey_s1   <= (sat_c == '0);
			sector_s1 <= h6[H6W-1:FW];
			f_s1      <= h6[FW-1:0];
			s_s1      <= sat_c;
			ns_s1     <= ONE_V - sat_c;
			v255_s1   <= v255;
			iv_s1     <= iv_sum[VW-1:FW];
			alpha_s1  <= a_sum[VW-1:FW];
		end
	end

	// ---------------- stage 2: s*f, s*(1-f), V*(1-s) ----------------
	logic [2*FW:0]   sf_full;
	logic [2*FW+1:0] sg_full;
	logic [FW:0]     one_minus_f;
	logic [PW-1:0]   xp;

	always_comb begin
		one_minus_f = ONE_V - {1'b0, f_s1};
		sf_full     = s_s1 * f_s1;
		sg_full     = s_s1 * one_minus_f;
		xp          = v255_s1 * ns_s1;
	end

	logic            grey_s2;
	logic [2:0]      sector_s2;
	logic [FW-1:0]   sf_s2;
	logic [FW:0]     sg_s2;
	logic [PW-1:0]   xp_s2;
	logic [VW-1:0]   v255_s2;
	logic [CW-1:0]   iv_s2, alpha_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			grey_s2   <= grey_s1;
			sector_s2 <= sector_s1;
			sf_s2     <= sf_full[2*FW-1:FW];
			sg_s2     <= sg_full[2*FW:FW];
			xp_s2     <= xp;
			v255_s2   <= v255_s1;
			iv_s2     <= iv_s1;
			alpha_s2  <= alpha_s1;
		end
	end

	// ---------------- stage 3: ramp products, round x ----------------
	logic [PW-1:0] yp, zp;

	always_comb begin
		yp = v255_s2 * (ONE_V - {1'b0, sf_s2});
		zp = v255_s2 * (ONE_V - sg_s2);
	end

	logic            grey_s3;
	logic [2:0]      sector_s3;
	logic [PW-1:0]   yp_s3, zp_s3;
	logic [CW-1:0]   x_s3, iv_s3, alpha_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			grey_s3   <= grey_s2;
			sector_s3 <= sector_s2;
			yp_s3     <= yp;
			zp_s3     <= zp;
			x_s3      <= round_prod(xp_s2);
			iv_s3     <= iv_s2;
			alpha_s3  <= alpha_s2;
		end
	end

	// ---------------- stage 4: round ramps, channel select ----------------
	logic [CW-1:0] y_c, z_c, r_c, g_c, b_c;

	always_comb begin
		y_c = round_prod(yp_s3);
		z_c = round_prod(zp_s3);
		if (grey_s3) begin
			r_c = iv_s3;
			g_c = iv_s3;
			b_c = iv_s3;
		end else begin
			case (hsv_pkg::sector_t'(sector_s3))
				hsv_pkg::SEC_RED_YEL: begin r_c = iv_s3; g_c = z_c;   b_c = x_s3;  end
				hsv_pkg::SEC_YEL_GRN: begin r_c = y_c;   g_c = iv_s3; b_c = x_s3;  end
				hsv_pkg::SEC_GRN_CYN: begin r_c = x_s3;  g_c = iv_s3; b_c = z_c;   end
				hsv_pkg::SEC_CYN_BLU: begin r_c = x_s3;  g_c = y_c;   b_c = iv_s3; end
				hsv_pkg::SEC_BLU_MAG: begin r_c = z_c;   g_c = x_s3;  b_c = iv_s3; end
				default:              begin r_c = iv_s3; g_c = x_s3;  b_c = y_c;   end
			endcase
		end
	end

	logic [CW-1:0] red_s4, green_s4, blue_s4, alpha_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			red_s4   <= r_c;
			green_s4 <= g_c;
			blue_s4  <= b_c;
			alpha_s4 <= alpha_s3;
		end
	end

	assign pixel_rgb.valid = v_s4;
	assign pixel_rgb.red   = red_s4;
	assign pixel_rgb.green = green_s4;
	assign pixel_rgb.blue  = blue_s4;
	assign pixel_rgb.alpha = alpha_s4;

endmodule

### sv/hsv_chk.sv
// ----------------------------------------------------------------------------
// hsv_chk: port-level checks for hsv_to_rgb_pixel
// Tracks pixels in flight and checks output flow control.
// ----------------------------------------------------------------------------
module hsv_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [hsv_pkg::PIX_W-1:0] red,
	input logic [hsv_pkg::PIX_W-1:0] green,
	input logic [hsv_pkg::PIX_W-1:0] blue,
	input logic [hsv_pkg::PIX_W-1:0] alpha
);

	logic       in_beat, out_beat;
	logic [2:0] cnt_q;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (in_beat && !out_beat) begin
			cnt_q <= cnt_q + 3'd1;
		end else if (out_beat && !in_beat) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// four stages hold at most four pixels
	a_depth: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("more pixels in flight than pipeline stages");

	// no output beat without a pixel taken in
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 3'd0)
		else $error("output beat with no pixel in flight");

	// an open output never throttles the input
	a_flow: assert property (@(posedge clk) disable iff (!arst_n) out_ready |-> in_ready)
		else $error("input stalled while output is ready");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({red, green, blue, alpha}))
		else $error("stalled output beat changed");

endmodule

bind hsv_to_rgb_pixel hsv_chk u_hsv_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel_hsv.valid),
	.in_ready  (pixel_hsv.ready),
	.out_valid (pixel_rgb.valid),
	.out_ready (pixel_rgb.ready),
	.red       (pixel_rgb.red),
	.green     (pixel_rgb.green),
	.blue      (pixel_rgb.blue),
	.alpha     (pixel_rgb.alpha)
);
